// ===== rtl/eedp_pkg.sv =====
package eedp_pkg;

    localparam logic [3:0] PH_TAG     = 4'd0;
    localparam logic [3:0] PH_LEN     = 4'd1;
    localparam logic [3:0] PH_NUM     = 4'd2;
    localparam logic [3:0] PH_LANG    = 4'd3;
    localparam logic [3:0] PH_LOOPLEN = 4'd4;
    localparam logic [3:0] PH_DLEN    = 4'd5;
    localparam logic [3:0] PH_DESC    = 4'd6;
    localparam logic [3:0] PH_ILEN    = 4'd7;
    localparam logic [3:0] PH_ITEM    = 4'd8;
    localparam logic [3:0] PH_TLEN    = 4'd9;
    localparam logic [3:0] PH_TEXT    = 4'd10;
    localparam logic [3:0] PH_TRAIL   = 4'd11;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERRUN = 2'd1;
    localparam logic [1:0] ST_EARLY   = 2'd2;

    localparam logic [7:0] LANG_BYTES = 8'd3;

    typedef struct packed {
        logic [3:0] byte_class;
        logic [7:0] byte_value;
        logic [6:0] item_number;
        logic [3:0] descriptor_num;
        logic [3:0] last_descriptor_num;
        logic [1:0] parse_status;
        logic       end_of_descriptor;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/eedp_if.sv =====
interface eedp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface eedp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] byte_class;
    logic [7:0] byte_value;
    logic [6:0] item_number;
    logic [3:0] descriptor_num;
    logic [3:0] last_descriptor_num;
    logic [1:0] parse_status;
    logic       end_of_descriptor;

    modport source (
        output valid, output byte_class, output byte_value, output item_number,
        output descriptor_num, output last_descriptor_num, output parse_status,
        output end_of_descriptor, input ready
    );
    modport sink (
        input valid, input byte_class, input byte_value, input item_number,
        input descriptor_num, input last_descriptor_num, input parse_status,
        input end_of_descriptor, output ready
    );
endinterface

// ===== rtl/eedp_front.sv =====
module eedp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    eedp_in_if.sink               data_chan,
    input  eedp_pkg::queue_status_t q_status,
    output logic                  push,
    output eedp_pkg::result_t     push_data
);

    logic [7:0] byte_position_reg, byte_position_next;
    logic [7:0] descriptor_length_reg, descriptor_length_next;
    logic [7:0] loop_length_reg, loop_length_next;
    logic [8:0] loop_consumed_reg, loop_consumed_next;
    logic [3:0] parse_phase_reg, parse_phase_next;
    logic [7:0] field_remaining_reg, field_remaining_next;
    logic [6:0] item_counter_reg, item_counter_next;
    logic [3:0] desc_num_reg, desc_num_next;
    logic [3:0] last_desc_num_reg, last_desc_num_next;
    logic [1:0] status_latch_reg, status_latch_next;

    logic       accept;
    logic [7:0] d;
    logic [3:0] cls;
    logic       eod;
    logic [6:0] item_out;
    logic [7:0] fr_dec;
    logic [8:0] lc_inc;
    logic [1:0] st_loop;

    assign data_chan.ready = !q_status.full;
    assign accept = data_chan.valid && data_chan.ready;
    assign d = data_chan.data_byte;

    always_comb
    begin
        // a flagged tag starts from cleared state
        if (data_chan.first_byte)
        begin
            byte_position_next     = '0;
            descriptor_length_next = '0;
            loop_length_next       = '0;
            loop_consumed_next     = '0;
            parse_phase_next       = eedp_pkg::PH_TAG;
            field_remaining_next   = '0;
            item_counter_next      = '0;
            desc_num_next          = '0;
            last_desc_num_next     = '0;
            status_latch_next      = eedp_pkg::ST_OK;
        end
        else
        begin
            byte_position_next     = byte_position_reg;
            descriptor_length_next = descriptor_length_reg;
            loop_length_next       = loop_length_reg;
            loop_consumed_next     = loop_consumed_reg;
            parse_phase_next       = parse_phase_reg;
            field_remaining_next   = field_remaining_reg;
            item_counter_next      = item_counter_reg;
            desc_num_next          = desc_num_reg;
            last_desc_num_next     = last_desc_num_reg;
            status_latch_next      = status_latch_reg;
        end

        cls = (parse_phase_next > eedp_pkg::PH_TRAIL) ? eedp_pkg::PH_TRAIL : parse_phase_next;
        item_out = item_counter_next;
        eod = 1'b0;

        if (cls != eedp_pkg::PH_TAG && cls != eedp_pkg::PH_LEN)
        begin
            eod = (descriptor_length_next != 8'd0) &&
                  (byte_position_next == descriptor_length_next - 8'd1);
            if (byte_position_next != 8'hff)
                byte_position_next = byte_position_next + 8'd1;
        end

        fr_dec = (field_remaining_next != 8'd0) ? field_remaining_next - 8'd1 : 8'd0;
        // loop byte count and overrun flag
        lc_inc = (loop_consumed_next != 9'h1ff) ? loop_consumed_next + 9'd1
                                                : loop_consumed_next;
        st_loop = ((lc_inc > {1'b0, loop_length_next}) &&
                   (status_latch_next == eedp_pkg::ST_OK)) ? eedp_pkg::ST_OVERRUN
                                                           : status_latch_next;

        case (cls)
            eedp_pkg::PH_TAG:
            begin
                parse_phase_next = eedp_pkg::PH_LEN;
            end
            eedp_pkg::PH_LEN:
            begin
                descriptor_length_next = d;
                byte_position_next = 8'd0;
                parse_phase_next = eedp_pkg::PH_NUM;
                eod = (d == 8'd0);
            end
            eedp_pkg::PH_NUM:
            begin
                desc_num_next = d[7:4];
                last_desc_num_next = d[3:0];
                field_remaining_next = eedp_pkg::LANG_BYTES;
                parse_phase_next = eedp_pkg::PH_LANG;
            end
            eedp_pkg::PH_LANG:
            begin
                field_remaining_next = fr_dec;
                if (fr_dec == 8'd0)
                    parse_phase_next = eedp_pkg::PH_LOOPLEN;
            end
            eedp_pkg::PH_LOOPLEN:
            begin
                loop_length_next = d;
                loop_consumed_next = 9'd0;
                parse_phase_next = (d != 8'd0) ? eedp_pkg::PH_DLEN : eedp_pkg::PH_TLEN;
            end
            eedp_pkg::PH_DLEN:
            begin
                loop_consumed_next = lc_inc;
                status_latch_next = st_loop;
                field_remaining_next = d;
                parse_phase_next = (d != 8'd0) ? eedp_pkg::PH_DESC : eedp_pkg::PH_ILEN;
            end
            eedp_pkg::PH_DESC:
            begin
                loop_consumed_next = lc_inc;
                status_latch_next = st_loop;
                field_remaining_next = fr_dec;
                if (fr_dec == 8'd0)
                    parse_phase_next = eedp_pkg::PH_ILEN;
            end
            eedp_pkg::PH_ILEN, eedp_pkg::PH_ITEM:
            begin
                loop_consumed_next = lc_inc;
                status_latch_next = st_loop;
                if (cls == eedp_pkg::PH_ILEN)
                    field_remaining_next = d;
                else
                    field_remaining_next = fr_dec;
                if ((cls == eedp_pkg::PH_ILEN && d != 8'd0) ||
                    (cls == eedp_pkg::PH_ITEM && fr_dec != 8'd0))
                begin
                    parse_phase_next = eedp_pkg::PH_ITEM;
                end
                else
                begin
                    // item done: next item or the text length
                    if (item_counter_next != 7'h7f)
                        item_counter_next = item_counter_next + 7'd1;
                    parse_phase_next = (lc_inc >= {1'b0, loop_length_next}) ?
                                       eedp_pkg::PH_TLEN : eedp_pkg::PH_DLEN;
                end
            end
            eedp_pkg::PH_TLEN:
            begin
                field_remaining_next = d;
                parse_phase_next = (d != 8'd0) ? eedp_pkg::PH_TEXT : eedp_pkg::PH_TRAIL;
            end
            eedp_pkg::PH_TEXT:
            begin
                field_remaining_next = fr_dec;
                if (fr_dec == 8'd0)
                    parse_phase_next = eedp_pkg::PH_TRAIL;
            end
            default:
            begin
                parse_phase_next = eedp_pkg::PH_TRAIL;
            end
        endcase

        if (eod)
        begin
            if (parse_phase_next != eedp_pkg::PH_TRAIL)
                status_latch_next = eedp_pkg::ST_EARLY;
            parse_phase_next = eedp_pkg::PH_TRAIL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg     <= '0;
            descriptor_length_reg <= '0;
            loop_length_reg       <= '0;
            loop_consumed_reg     <= '0;
            parse_phase_reg       <= eedp_pkg::PH_TAG;
            field_remaining_reg   <= '0;
            item_counter_reg      <= '0;
            desc_num_reg          <= '0;
            last_desc_num_reg     <= '0;
            status_latch_reg      <= eedp_pkg::ST_OK;
        end
        else if (accept)
        begin
            byte_position_reg     <= byte_position_next;
            descriptor_length_reg <= descriptor_length_next;
            loop_length_reg       <= loop_length_next;
            loop_consumed_reg     <= loop_consumed_next;
            parse_phase_reg       <= parse_phase_next;
            field_remaining_reg   <= field_remaining_next;
            item_counter_reg      <= item_counter_next;
            desc_num_reg          <= desc_num_next;
            last_desc_num_reg     <= last_desc_num_next;
            status_latch_reg      <= status_latch_next;
        end
    end

    assign push = accept;

    always_comb
    begin
        push_data.byte_class          = cls;
        push_data.byte_value          = d;
        push_data.item_number         = item_out;
        push_data.descriptor_num      = desc_num_next;
        push_data.last_descriptor_num = last_desc_num_next;
        push_data.parse_status        = status_latch_next;
        push_data.end_of_descriptor   = eod;
    end

endmodule

// ===== rtl/eedp_queue.sv =====
module eedp_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  eedp_pkg::result_t       push_data,
    input  logic                    pop,
    output eedp_pkg::result_t       pop_data,
    output eedp_pkg::queue_status_t status
);

    eedp_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/eedp_back.sv =====
module eedp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  eedp_pkg::queue_status_t q_status,
    input  eedp_pkg::result_t       q_data,
    output logic                    pop,
    eedp_out_if.source              result_chan
);

    logic              out_valid_reg, out_valid_next;
    eedp_pkg::result_t out_data_reg;

    // refill the output register from the queue, when the queue is not empty, whenever it is empty or being taken
    assign pop = !q_status.empty && (!out_valid_reg || result_chan.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (result_chan.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_data_reg <= q_data;
    end

    assign result_chan.valid               = out_valid_reg;
    assign result_chan.byte_class          = out_data_reg.byte_class;
    assign result_chan.byte_value          = out_data_reg.byte_value;
    assign result_chan.item_number         = out_data_reg.item_number;
    assign result_chan.descriptor_num      = out_data_reg.descriptor_num;
    assign result_chan.last_descriptor_num = out_data_reg.last_descriptor_num;
    assign result_chan.parse_status        = out_data_reg.parse_status;
    assign result_chan.end_of_descriptor   = out_data_reg.end_of_descriptor;

endmodule

// ===== rtl/extended_event_descriptor_parser.sv =====
// an accepted byte is written into the queue, then moved into the output register that drives the result port
// throughput: one byte per cycle while the queue is not full, set by the parse state update in the front
// a two-entry queue sits between the parser and the output register; with the output
// stalled the input stalls once the queue holds two items
// reset (rst_n low, asynchronous): parser returns to expect tag with all counts cleared,
// queue and output register empty
module extended_event_descriptor_parser (
    input  logic       clk,
    input  logic       rst_n,
    eedp_in_if.sink    data_chan,
    eedp_out_if.source result_chan
);

    eedp_pkg::queue_status_t q_status;
    eedp_pkg::result_t       q_push_data;
    eedp_pkg::result_t       q_pop_data;
    logic                    q_push;
    logic                    q_pop;

    eedp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_chan (data_chan),
        .q_status  (q_status),
        .push      (q_push),
        .push_data (q_push_data)
    );

    eedp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    eedp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_data      (q_pop_data),
        .pop         (q_pop),
        .result_chan (result_chan)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !q_push)
        else $error("item pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !q_pop)
        else $error("pop from empty queue");

    a_status_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue both full and empty");

    a_eod_not_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (result_chan.valid && result_chan.end_of_descriptor) |->
        (result_chan.byte_class != eedp_pkg::PH_TAG))
        else $error("end of descriptor flagged on a tag byte");

endmodule

// ===== verif/testbench.sv =====
module testbench;

    localparam int ITEM_BUDGET = 1700;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic              typed;
        logic              flag;
        logic [7:0]        data;
        eedp_pkg::result_t want;
    } stim_row_t;

    localparam eedp_pkg::result_t NO_CHECK = '0;

    logic clk;
    logic rst_n;

    eedp_in_if  data_chan ();
    eedp_out_if result_chan ();

    extended_event_descriptor_parser uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_chan   (data_chan),
        .result_chan (result_chan)
    );

    // directed walk: unflagged start, zero length, trailing, extremes, loop overrun
    stim_row_t directed_rows [0:25] = '{
        '{1'b1, 1'b0, 8'h4E,
          '{eedp_pkg::PH_TAG, 8'h4E, 7'd0, 4'd0, 4'd0, eedp_pkg::ST_OK, 1'b0}},
        '{1'b1, 1'b0, 8'h00,
          '{eedp_pkg::PH_LEN, 8'h00, 7'd0, 4'd0, 4'd0, eedp_pkg::ST_EARLY, 1'b1}},
        '{1'b1, 1'b0, 8'hFF,
          '{eedp_pkg::PH_TRAIL, 8'hFF, 7'd0, 4'd0, 4'd0, eedp_pkg::ST_EARLY, 1'b0}},
        '{1'b1, 1'b1, 8'hFF,
          '{eedp_pkg::PH_TAG, 8'hFF, 7'd0, 4'd0, 4'd0, eedp_pkg::ST_OK, 1'b0}},
        '{1'b1, 1'b0, 8'hFF,
          '{eedp_pkg::PH_LEN, 8'hFF, 7'd0, 4'd0, 4'd0, eedp_pkg::ST_OK, 1'b0}},
        '{1'b1, 1'b0, 8'hFF,
          '{eedp_pkg::PH_NUM, 8'hFF, 7'd0, 4'd15, 4'd15, eedp_pkg::ST_OK, 1'b0}},
        '{1'b0, 1'b0, 8'h00, NO_CHECK},
        '{1'b0, 1'b0, 8'h80, NO_CHECK},
        '{1'b0, 1'b0, 8'h7F, NO_CHECK},
        '{1'b1, 1'b0, 8'h00,
          '{eedp_pkg::PH_LOOPLEN, 8'h00, 7'd0, 4'd15, 4'd15, eedp_pkg::ST_OK, 1'b0}},
        '{1'b1, 1'b0, 8'h00,
          '{eedp_pkg::PH_TLEN, 8'h00, 7'd0, 4'd15, 4'd15, eedp_pkg::ST_OK, 1'b0}},
        '{1'b0, 1'b0, 8'h55, NO_CHECK},
        '{1'b1, 1'b1, 8'h4E,
          '{eedp_pkg::PH_TAG, 8'h4E, 7'd0, 4'd0, 4'd0, eedp_pkg::ST_OK, 1'b0}},
        '{1'b0, 1'b0, 8'h0C, NO_CHECK},
        '{1'b1, 1'b0, 8'h31,
          '{eedp_pkg::PH_NUM, 8'h31, 7'd0, 4'd3, 4'd1, eedp_pkg::ST_OK, 1'b0}},
        '{1'b0, 1'b0, 8'h65, NO_CHECK},
        '{1'b0, 1'b0, 8'h6E, NO_CHECK},
        '{1'b0, 1'b0, 8'h67, NO_CHECK},
        '{1'b0, 1'b0, 8'h02, NO_CHECK},
        '{1'b0, 1'b0, 8'h01, NO_CHECK},
        '{1'b0, 1'b0, 8'hAA, NO_CHECK},
        '{1'b1, 1'b0, 8'h01,
          '{eedp_pkg::PH_ILEN, 8'h01, 7'd0, 4'd3, 4'd1, eedp_pkg::ST_OVERRUN, 1'b0}},
        '{1'b0, 1'b0, 8'hBB, NO_CHECK},
        '{1'b1, 1'b0, 8'h02,
          '{eedp_pkg::PH_TLEN, 8'h02, 7'd1, 4'd3, 4'd1, eedp_pkg::ST_OVERRUN, 1'b0}},
        '{1'b0, 1'b0, 8'hC0, NO_CHECK},
        '{1'b1, 1'b0, 8'hC1,
          '{eedp_pkg::PH_TEXT, 8'hC1, 7'd1, 4'd3, 4'd1, eedp_pkg::ST_OVERRUN, 1'b1}}
    };

    // parser state mirror
    logic [7:0] pos_q;
    logic [7:0] desc_len_q;
    logic [7:0] loop_len_q;
    logic [8:0] consumed_q;
    logic [3:0] phase_q;
    logic [7:0] remain_q;
    logic [6:0] items_q;
    logic [3:0] dnum_q;
    logic [3:0] last_dnum_q;
    logic [1:0] status_q;

    eedp_pkg::result_t pending_results [$];
    logic [7:0]        desc_bytes [$];
    logic              desc_flags [$];

    int  errors;
    int  bytes_sent;
    int  bytes_checked;
    int  ends_clean;
    int  ends_overrun;
    int  ends_early;
    int  cycles;
    logic tx_burst;
    logic rx_burst;

    function automatic void clear_parse();
        pos_q       = '0;
        desc_len_q  = '0;
        loop_len_q  = '0;
        consumed_q  = '0;
        phase_q     = eedp_pkg::PH_TAG;
        remain_q    = '0;
        items_q     = '0;
        dnum_q      = '0;
        last_dnum_q = '0;
        status_q    = eedp_pkg::ST_OK;
    endfunction

    function automatic void take_loop_byte();
        if (consumed_q != 9'd511)
            consumed_q = consumed_q + 9'd1;
        if (consumed_q > {1'b0, loop_len_q} && status_q == eedp_pkg::ST_OK)
            status_q = eedp_pkg::ST_OVERRUN;
    endfunction

    function automatic void close_item();
        if (items_q != 7'd127)
            items_q = items_q + 7'd1;
        phase_q = (consumed_q >= {1'b0, loop_len_q}) ? eedp_pkg::PH_TLEN
                                                     : eedp_pkg::PH_DLEN;
    endfunction

    function automatic logic field_done();
        if (remain_q != 0)
            remain_q = remain_q - 8'd1;
        return remain_q == 0;
    endfunction

    function automatic eedp_pkg::result_t parse_byte(input logic [7:0] d, input logic flag);
        eedp_pkg::result_t r;
        logic [3:0]        cls;
        logic              eod;
        if (flag)
            clear_parse();
        cls = (phase_q > eedp_pkg::PH_TRAIL) ? eedp_pkg::PH_TRAIL : phase_q;
        r.item_number = items_q;
        eod = 1'b0;
        if (cls != eedp_pkg::PH_TAG && cls != eedp_pkg::PH_LEN)
        begin
            eod = (desc_len_q != 0) && (pos_q == desc_len_q - 8'd1);
            if (pos_q != 8'hFF)
                pos_q = pos_q + 8'd1;
        end
        case (cls)
            eedp_pkg::PH_TAG:
                phase_q = eedp_pkg::PH_LEN;
            eedp_pkg::PH_LEN:
            begin
                desc_len_q = d;
                pos_q      = '0;
                phase_q    = eedp_pkg::PH_NUM;
                eod        = (d == 0);
            end
            eedp_pkg::PH_NUM:
            begin
                dnum_q      = d[7:4];
                last_dnum_q = d[3:0];
                remain_q    = eedp_pkg::LANG_BYTES;
                phase_q     = eedp_pkg::PH_LANG;
            end
            eedp_pkg::PH_LANG:
                if (field_done())
                    phase_q = eedp_pkg::PH_LOOPLEN;
            eedp_pkg::PH_LOOPLEN:
            begin
                loop_len_q = d;
                consumed_q = '0;
                phase_q    = (d != 0) ? eedp_pkg::PH_DLEN : eedp_pkg::PH_TLEN;
            end
            eedp_pkg::PH_DLEN:
            begin
                take_loop_byte();
                remain_q = d;
                phase_q  = (d != 0) ? eedp_pkg::PH_DESC : eedp_pkg::PH_ILEN;
            end
            eedp_pkg::PH_DESC:
            begin
                take_loop_byte();
                if (field_done())
                    phase_q = eedp_pkg::PH_ILEN;
            end
            eedp_pkg::PH_ILEN:
            begin
                take_loop_byte();
                remain_q = d;
                if (d != 0)
                    phase_q = eedp_pkg::PH_ITEM;
                else
                    close_item();
            end
            eedp_pkg::PH_ITEM:
            begin
                take_loop_byte();
                if (field_done())
                    close_item();
            end
            eedp_pkg::PH_TLEN:
            begin
                remain_q = d;
                phase_q  = (d != 0) ? eedp_pkg::PH_TEXT : eedp_pkg::PH_TRAIL;
            end
            eedp_pkg::PH_TEXT:
                if (field_done())
                    phase_q = eedp_pkg::PH_TRAIL;
            default:
                phase_q = eedp_pkg::PH_TRAIL;
        endcase
        if (eod)
        begin
            if (phase_q != eedp_pkg::PH_TRAIL)
                status_q = eedp_pkg::ST_EARLY;
            phase_q = eedp_pkg::PH_TRAIL;
        end
        r.byte_class          = cls;
        r.byte_value          = d;
        r.descriptor_num      = dnum_q;
        r.last_descriptor_num = last_dnum_q;
        r.parse_status        = status_q;
        r.end_of_descriptor   = eod;
        return r;
    endfunction

    task automatic send_byte(input logic flag, input logic [7:0] d, input logic typed,
                             input eedp_pkg::result_t want);
        int                gap;
        eedp_pkg::result_t predicted;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            data_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_chan.valid      <= 1'b1;
        data_chan.data_byte  <= d;
        data_chan.first_byte <= flag;
        @(posedge clk);
        while (!data_chan.ready)
            @(posedge clk);
        predicted = parse_byte(d, flag);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        data_chan.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_byte(input logic flag, input logic [7:0] d);
        desc_flags.insert(desc_flags.size(), flag);
        desc_bytes.insert(desc_bytes.size(), d);
    endtask

    // mostly well-formed descriptors; some with a wrong loop length, a short or long
    // length field, cut off by the next tag, or plain noise
    task automatic make_descriptor();
        int         kind;
        int         n_items;
        int         field_len;
        int         loop_sum;
        int         text_len;
        int         total;
        int         len_field;
        int         cut;
        logic [7:0] loop_body [$];
        logic [7:0] loop_len;
        desc_bytes.delete();
        desc_flags.delete();
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 8))
                add_byte($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
            return;
        end
        n_items = (kind == 1) ? $urandom_range(20, 60) : $urandom_range(0, 4);
        repeat (n_items)
        begin
            for (int j = 0; j < 2; j++)
            begin
                field_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                loop_body.insert(loop_body.size(), 8'(field_len));
                repeat (field_len)
                    loop_body.insert(loop_body.size(), 8'($urandom_range(0, 255)));
            end
        end
        loop_sum = loop_body.size();
        loop_len = (loop_sum > 255) ? 8'hFF : 8'(loop_sum);
        if (kind == 2 || kind == 3)
            loop_len = 8'($urandom_range(0, (loop_sum + 3 > 255) ? 255 : loop_sum + 3));
        text_len = $urandom_range(0, 8);
        total = 6 + loop_sum + text_len;
        len_field = (total > 255) ? 255 : total;
        if (kind == 4 || kind == 5)
            len_field = $urandom_range(0, len_field);
        else if (kind == 6)
        begin
            len_field = len_field + $urandom_range(1, 6);
            if (len_field > 255)
                len_field = 255;
        end
        add_byte(1'b1, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h4E);
        add_byte(1'b0, 8'(len_field));
        repeat (4)
            add_byte(1'b0, 8'($urandom_range(0, 255)));
        add_byte(1'b0, loop_len);
        foreach (loop_body[k])
            add_byte(1'b0, loop_body[k]);
        add_byte(1'b0, 8'(text_len));
        repeat (text_len)
            add_byte(1'b0, 8'($urandom_range(0, 255)));
        if (kind == 6 || $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 6))
                add_byte(1'b0, 8'($urandom_range(0, 255)));
        if (kind == 7)
        begin
            cut = $urandom_range(1, desc_bytes.size() - 1);
            while (desc_bytes.size() > cut)
            begin
                void'(desc_bytes.pop_back());
                void'(desc_flags.pop_back());
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        eedp_pkg::result_t want;
        if (rst_n && result_chan.valid && result_chan.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual class %0d value %0d",
                         $time, result_chan.byte_class, result_chan.byte_value);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("byte_class", 8'(want.byte_class),
                            8'(result_chan.byte_class));
                check_field("byte_value", want.byte_value, result_chan.byte_value);
                check_field("item_number", 8'(want.item_number),
                            8'(result_chan.item_number));
                check_field("descriptor_num", 8'(want.descriptor_num),
                            8'(result_chan.descriptor_num));
                check_field("last_descriptor_num", 8'(want.last_descriptor_num),
                            8'(result_chan.last_descriptor_num));
                check_field("parse_status", 8'(want.parse_status),
                            8'(result_chan.parse_status));
                check_field("end_of_descriptor", 8'(want.end_of_descriptor),
                            8'(result_chan.end_of_descriptor));
                bytes_checked++;
                if (want.end_of_descriptor)
                begin
                    if (want.parse_status == eedp_pkg::ST_OK)
                        ends_clean++;
                    else if (want.parse_status == eedp_pkg::ST_OVERRUN)
                        ends_overrun++;
                    else
                        ends_early++;
                end
            end
        end
    end

    // result side: random stall before each item, with stretches of no stall
    initial
    begin
        int stall;
        result_chan.ready <= 1'b0;
        rx_burst = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                rx_burst = ~rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 13);
            if (stall != 0)
            begin
                result_chan.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_chan.ready <= 1'b1;
            @(posedge clk);
            while (!result_chan.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int n_desc;
        errors        = 0;
        bytes_sent    = 0;
        bytes_checked = 0;
        ends_clean    = 0;
        ends_overrun  = 0;
        ends_early    = 0;
        cycles        = 0;
        n_desc        = 0;
        tx_burst      = 1'b0;
        clear_parse();
        rst_n                <= 1'b0;
        data_chan.valid      <= 1'b0;
        data_chan.data_byte  <= 8'h00;
        data_chan.first_byte <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].flag, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].want);

        while (bytes_sent < ITEM_BUDGET)
        begin
            // hold off now and then until the parser has emptied
            if (n_desc == 0 || $urandom_range(0, 24) == 0)
                wait_drained();
            tx_burst = ($urandom_range(0, 3) == 0);
            make_descriptor();
            foreach (desc_bytes[k])
                send_byte(desc_flags[k], desc_bytes[k], 1'b0, NO_CHECK);
            n_desc++;
        end

        wait_drained();
        repeat (16) @(posedge clk);
        $display("%0d bytes sent (directed table plus %0d random descriptors), %0d checked",
                 bytes_sent, n_desc, bytes_checked);
        $display("descriptor ends: %0d clean, %0d after loop overrun, %0d early",
                 ends_clean, ends_overrun, ends_early);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
